[rtl/core/smeu_pkg.sv]
// ----------------------------------------------------------------------------
// smeu_pkg
// Opcodes, fault codes and shared types of the stack machine execute unit.
// ----------------------------------------------------------------------------
package smeu_pkg;

  localparam logic [4:0] OP_ADD   = 5'd0;
  localparam logic [4:0] OP_SUB   = 5'd1;
  localparam logic [4:0] OP_MUL   = 5'd2;
  localparam logic [4:0] OP_DIV   = 5'd3;
  localparam logic [4:0] OP_SHL   = 5'd4;
  localparam logic [4:0] OP_SHR   = 5'd5;
  localparam logic [4:0] OP_GT    = 5'd6;
  localparam logic [4:0] OP_LT    = 5'd7;
  localparam logic [4:0] OP_NOT   = 5'd8;
  localparam logic [4:0] OP_JMP   = 5'd9;
  localparam logic [4:0] OP_BZ    = 5'd10;
  localparam logic [4:0] OP_BNZ   = 5'd11;
  localparam logic [4:0] OP_PUSH  = 5'd12;
  localparam logic [4:0] OP_RSV   = 5'd13;
  localparam logic [4:0] OP_DROP  = 5'd14;
  localparam logic [4:0] OP_LOAD  = 5'd15;
  localparam logic [4:0] OP_STORE = 5'd16;
  localparam logic [4:0] OP_EMIT  = 5'd17;
  localparam logic [4:0] OP_PRO   = 5'd18;
  localparam logic [4:0] OP_RET   = 5'd19;
  localparam logic [4:0] OP_CALL  = 5'd20;
  localparam logic [4:0] OP_EXIT  = 5'd21;

  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_OP    = 3'd1;
  localparam logic [2:0] FLT_DIV0  = 3'd2;
  localparam logic [2:0] FLT_OVER  = 3'd3;
  localparam logic [2:0] FLT_UNDER = 3'd4;
  localparam logic [2:0] FLT_PRINT = 3'd5;

  typedef struct packed {
    logic       start;
    logic [1:0] kind;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  localparam logic [1:0] ALU_MUL = 2'd0;
  localparam logic [1:0] ALU_DIV = 2'd1;

  typedef struct packed {
    logic       done;
    logic [63:0] res;
  } alu_rsp_t;

endpackage

[rtl/core/stack_machine_execute_unit_core.sv]
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_core
// Executes one decoded instruction of a 64-bit word stack machine per item.
// ----------------------------------------------------------------------------
// Each instruction reads its operands from the single-port stack RAM one
// word at a time, executes, and writes at most one word before its result
// item; multiply and divide run in the shared arithmetic unit, and print
// emits one result item per printed word. The input is not ready while an
// instruction runs or its result waits.
module stack_machine_execute_unit_core #(
  parameter int STACK_WORDS    = 1024,
  parameter int MAX_PRINT_ARGS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // cmd[4:0], operand[68:5], after_pc[100:69]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // next_pc[31:0], print_valid[32],
                                  // print_value[96:33], halted[97], fault[100:98]
  output logic         m_tlast
);
  import smeu_pkg::*;

  localparam int AW = $clog2(STACK_WORDS);
  localparam int TW = AW + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD1   = 4'd1;
  localparam logic [3:0] S_RD1W  = 4'd2;
  localparam logic [3:0] S_RD2   = 4'd3;
  localparam logic [3:0] S_RD2W  = 4'd4;
  localparam logic [3:0] S_EXEC  = 4'd5;
  localparam logic [3:0] S_ALU   = 4'd6;
  localparam logic [3:0] S_WR    = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_PRD   = 4'd9;
  localparam logic [3:0] S_PRW   = 4'd10;
  localparam logic [3:0] S_POUT  = 4'd11;

  logic [3:0]   state;
  logic [4:0]   cmd;
  logic [63:0]  opd;
  logic [31:0]  pc;
  logic [TW-1:0] top;
  logic [TW-1:0] fb;
  logic         stopped;
  logic [63:0]  wa;
  logic [63:0]  wb;
  logic [63:0]  wr_data;
  logic [AW-1:0] wr_addr;
  logic [TW-1:0] new_top;
  logic [TW-1:0] pidx;
  logic [TW-1:0] pend;

  logic         ram_we;
  logic [AW-1:0] ram_addr;
  logic [AW-1:0] rd_addr;
  logic [63:0]  ram_q;

  alu_req_t     areq;
  alu_rsp_t     arsp;

  logic [31:0]  o_pc;
  logic         o_pv;
  logic [63:0]  o_val;
  logic         o_last;
  logic         o_halt;
  logic [2:0]   o_flt;

  // Precheck values
  logic signed [64:0] t_s;
  logic signed [64:0] n_s;
  logic signed [65:0] fidx;
  logic [2:0]   pre_f;
  logic [1:0]   nrd;
  logic [AW-1:0] ra1;
  logic [AW-1:0] ra2;
  logic         print_empty;

  assign t_s  = 65'(top);
  assign n_s  = {opd[63], opd};
  assign fidx = 66'(fb) + {{5{opd[63]}}, opd[63:3]};

  smeu_ram #(.WIDTH(64), .DEPTH(STACK_WORDS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wr_data), .rdata(ram_q)
  );

  smeu_alu u_alu (.clk(clk), .rst(rst), .req(areq), .rsp(arsp));

  always_comb begin
    pre_f = FLT_NONE;
    nrd   = 2'd0;
    ra1   = AW'(top - TW'(1));
    ra2   = AW'(top - TW'(2));
    print_empty = 1'b0;
    unique case (cmd)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SHL, OP_SHR, OP_GT, OP_LT: begin
        nrd = 2'd2;
        if (top < TW'(2)) pre_f = FLT_UNDER;
      end
      OP_NOT, OP_JMP, OP_BZ, OP_BNZ, OP_CALL: begin
        nrd = 2'd1;
        if (top < TW'(1)) pre_f = FLT_UNDER;
      end
      OP_PUSH, OP_PRO: begin
        if (top >= TW'(STACK_WORDS)) pre_f = FLT_OVER;
      end
      OP_RSV: begin
        if (n_s > 65'(STACK_WORDS) - t_s) pre_f = FLT_OVER;
        else if (n_s < -t_s) pre_f = FLT_UNDER;
      end
      OP_DROP: begin
        if (n_s > t_s) pre_f = FLT_UNDER;
        else if (n_s < t_s - 65'(STACK_WORDS)) pre_f = FLT_OVER;
      end
      OP_LOAD: begin
        nrd = 2'd1;
        ra1 = AW'(fidx);
        if (fidx < 0) pre_f = FLT_UNDER;
        else if (fidx >= 66'(STACK_WORDS)) pre_f = FLT_OVER;
        else if (top >= TW'(STACK_WORDS)) pre_f = FLT_OVER;
      end
      OP_STORE: begin
        nrd = 2'd1;
        if (top < TW'(1)) pre_f = FLT_UNDER;
        else if (fidx < 0) pre_f = FLT_UNDER;
        else if (fidx >= 66'(STACK_WORDS)) pre_f = FLT_OVER;
      end
      OP_EMIT: begin
        if (opd > 64'(MAX_PRINT_ARGS)) pre_f = FLT_PRINT;
        else if (opd > 64'(top)) pre_f = FLT_UNDER;
        else if (opd == 64'd0) print_empty = 1'b1;
      end
      OP_RET: begin
        nrd = 2'd2;
        ra1 = AW'(fb - TW'(1));
        ra2 = AW'(fb - TW'(2));
        if (fb < TW'(2)) pre_f = FLT_UNDER;
      end
      OP_EXIT: ;
      default: pre_f = FLT_OP;
    endcase
  end

  always_comb begin
    ram_we   = (state == S_WR);
    ram_addr = (state == S_WR) ? wr_addr : rd_addr;
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT) || (state == S_POUT);
  assign m_tlast  = o_last;
  assign m_tdata  = {3'd0, o_flt, o_halt, o_val, o_pv, o_pc};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      top     <= '0;
      fb      <= '0;
      stopped <= 1'b0;
      areq.start <= 1'b0;
    end else begin
      areq.start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd   <= s_tdata[4:0];
            opd   <= s_tdata[68:5];
            pc    <= s_tdata[100:69];
            state <= S_RD1;
          end
        end
        S_RD1: begin
          o_pc   <= pc;
          o_pv   <= 1'b0;
          o_val  <= '0;
          o_last <= 1'b1;
          o_flt  <= FLT_NONE;
          o_halt <= stopped;
          if (stopped) begin
            state <= S_OUT;
          end else if (pre_f != FLT_NONE) begin
            stopped <= 1'b1;
            o_halt  <= 1'b1;
            o_flt   <= pre_f;
            state   <= S_OUT;
          end else if (cmd == OP_EMIT) begin
            if (print_empty) begin
              state <= S_OUT;
            end else begin
              pidx    <= top - TW'(opd[6:0]);
              pend    <= top;
              new_top <= top - TW'(opd[6:0]);
              rd_addr <= AW'(top - TW'(opd[6:0]));
              state   <= S_PRD;
            end
          end else if (nrd != 2'd0) begin
            rd_addr <= ra1;
            state   <= S_RD1W;
          end else begin
            state <= S_EXEC;
          end
        end
        S_RD1W: begin
          rd_addr <= ra2;
          state   <= (nrd == 2'd2) ? S_RD2 : S_EXEC;
        end
        S_RD2: begin
          wa    <= ram_q;
          state <= S_RD2W;
        end
        S_RD2W: begin
          wb    <= ram_q;
          state <= S_EXEC;
        end
        S_EXEC: begin
          logic [63:0] a;
          a = (nrd == 2'd1) ? ram_q : wa;
          new_top <= top;
          state   <= S_OUT;
          unique case (cmd)
            OP_ADD, OP_SUB, OP_SHL, OP_SHR, OP_GT, OP_LT: begin
              wr_addr <= AW'(top - TW'(2));
              new_top <= top - TW'(1);
              state   <= S_WR;
              unique case (cmd)
                OP_ADD: wr_data <= a + wb;
                OP_SUB: wr_data <= a - wb;
                OP_SHL: wr_data <= (wb >= 64'd64) ? 64'd0 : (a << wb[5:0]);
                OP_SHR: wr_data <= (wb >= 64'd64) ? {64{a[63]}}
                                    : 64'($signed(a) >>> wb[5:0]);
                OP_GT:  wr_data <= {63'd0, $signed(a) > $signed(wb)};
                default: wr_data <= {63'd0, $signed(a) < $signed(wb)};
              endcase
            end
            OP_MUL, OP_DIV: begin
              if (cmd == OP_DIV && wb == 64'd0) begin
                stopped <= 1'b1;
                o_halt  <= 1'b1;
                o_flt   <= FLT_DIV0;
              end else begin
                areq.start <= 1'b1;
                areq.kind  <= (cmd == OP_MUL) ? ALU_MUL : ALU_DIV;
                areq.a     <= a;
                areq.b     <= wb;
                wa         <= a;
                wr_addr    <= AW'(top - TW'(2));
                new_top    <= top - TW'(1);
                state      <= S_ALU;
              end
            end
            OP_NOT: begin
              wr_addr <= AW'(top - TW'(1));
              wr_data <= {63'd0, a == 64'd0};
              state   <= S_WR;
            end
            OP_JMP: begin
              top  <= top - TW'(1);
              o_pc <= a[31:0];
            end
            OP_BZ, OP_BNZ: begin
              top <= top - TW'(1);
              if ((a == 64'd0) == (cmd == OP_BZ)) o_pc <= pc + opd[31:0];
            end
            OP_CALL: begin
              wr_addr <= AW'(top - TW'(1));
              wr_data <= {32'd0, pc};
              o_pc    <= a[31:0];
              state   <= S_WR;
            end
            OP_PUSH: begin
              wr_addr <= AW'(top);
              wr_data <= opd;
              new_top <= top + TW'(1);
              state   <= S_WR;
            end
            OP_PRO: begin
              wr_addr <= AW'(top);
              wr_data <= 64'(fb);
              new_top <= top + TW'(1);
              fb      <= top + TW'(1);
              state   <= S_WR;
            end
            OP_RSV: top <= top + TW'(opd);
            OP_DROP: top <= top - TW'(opd);
            OP_LOAD: begin
              wr_addr <= AW'(top);
              wr_data <= a;
              new_top <= top + TW'(1);
              state   <= S_WR;
            end
            OP_STORE: begin
              wr_addr <= AW'(fidx);
              wr_data <= a;
              new_top <= top - TW'(1);
              state   <= S_WR;
            end
            OP_RET: begin
              if (wa > 64'(STACK_WORDS)) begin
                stopped <= 1'b1;
                o_halt  <= 1'b1;
                o_flt   <= FLT_OVER;
              end else begin
                top  <= fb - TW'(2);
                fb   <= TW'(wa);
                o_pc <= wb[31:0];
              end
            end
            OP_EXIT: begin
              stopped <= 1'b1;
              o_halt  <= 1'b1;
            end
            default: ;
          endcase
        end
        S_ALU: begin
          if (arsp.done) begin
            if (areq.kind == ALU_DIV && wa == 64'h8000_0000_0000_0000
                && wb == '1) begin
              wr_data <= wa;
            end else begin
              wr_data <= arsp.res;
            end
            state <= S_WR;
          end
        end
        S_WR: begin
          top   <= new_top;
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) state <= S_IDLE;
        end
        S_PRD: begin
          rd_addr <= AW'(pidx);
          state   <= S_PRW;
        end
        S_PRW: begin
          state <= S_PRD;
          if (rd_addr == AW'(pidx)) begin
            o_pv   <= 1'b1;
            o_val  <= ram_q;
            o_last <= (pidx + TW'(1) == pend);
            state  <= S_POUT;
          end
        end
        S_POUT: begin
          if (m_tready) begin
            if (o_last) begin
              top   <= new_top;
              state <= S_IDLE;
            end else begin
              pidx    <= pidx + TW'(1);
              rd_addr <= AW'(pidx + TW'(1));
              state   <= S_PRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/smeu_ram.sv]
// ----------------------------------------------------------------------------
// smeu_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module smeu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/core/smeu_alu.sv]
// ----------------------------------------------------------------------------
// smeu_alu
// Shared multicycle unit: 64-bit multiply by 16-bit partial products and
// signed truncating divide one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smeu_alu (
  input  logic                clk,
  input  logic                rst,
  input  smeu_pkg::alu_req_t  req,
  output smeu_pkg::alu_rsp_t  rsp
);
  import smeu_pkg::*;

  logic        busy;
  logic        done;
  logic [1:0]  kind;
  logic [6:0]  cnt;
  logic [63:0] x;
  logic [63:0] y;
  logic [63:0] acc;
  logic [63:0] rem;
  logic        neg;
  logic [64:0] diff;
  logic [63:0] pp;
  logic [63:0] mag_a;
  logic [63:0] mag_b;

  assign mag_a = req.a[63] ? (~req.a + 64'd1) : req.a;
  assign mag_b = req.b[63] ? (~req.b + 64'd1) : req.b;
  assign diff  = {rem[62:0], x[63]} - {1'b0, y};
  assign pp    = {48'd0, y[15:0]} * x;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        kind <= req.kind;
        acc  <= '0;
        rem  <= '0;
        if (req.kind == ALU_MUL) begin
          x   <= req.a;
          y   <= req.b;
          cnt <= 7'd4;
        end else begin
          x   <= mag_a;
          y   <= mag_b;
          neg <= req.a[63] ^ req.b[63];
          cnt <= 7'd64;
        end
      end else if (busy) begin
        if (kind == ALU_MUL) begin
          acc <= acc + pp;
          x   <= {x[47:0], 16'd0};
          y   <= {16'd0, y[63:16]};
        end else begin
          x <= {x[62:0], 1'b0};
          if (!diff[64]) begin
            rem <= diff[63:0];
            acc <= {acc[62:0], 1'b1};
          end else begin
            rem <= {rem[62:0], x[63]};
            acc <= {acc[62:0], 1'b0};
          end
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    if (kind == ALU_DIV && neg) begin
      rsp.res = ~acc + 64'd1;
    end else begin
      rsp.res = acc;
    end
  end
endmodule
